[sv/tbsa_pkg.sv]
`timescale 1ns / 1ps

package tbsa_pkg;

    localparam int MAX_SAMPLES_PER_BIN = 4096;

    localparam int TIME_W = 32;
    localparam int BIN_W  = 24;
    localparam int DATA_W = 32;
    localparam int OTIME_W = TIME_W + 1;

    // count holds 0 .. MAX_SAMPLES_PER_BIN
    localparam int CNT_W  = $clog2(MAX_SAMPLES_PER_BIN + 1);
    // magnitude of a sum stays below 2**(DATA_W-1) * 2**CNT_W
    localparam int DIV_W  = DATA_W - 1 + CNT_W;
    localparam int SUM_W  = DIV_W + 1;
    localparam int STEP_W = $clog2(DIV_W);

    localparam int LANES = 3;

    localparam int APB_AW = 3;
    localparam logic REG_BIN_SECONDS  = 1'b0;
    localparam logic REG_PERIOD_START = 1'b1;

    localparam logic [BIN_W-1:0]  BIN_SECONDS_RST  = BIN_W'(3600);
    localparam logic [TIME_W-1:0] PERIOD_START_RST = '0;

    typedef struct packed {
        logic [TIME_W-1:0]        sample_time;
        logic                     sample_valid;
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] sample_rms;
        logic signed [DATA_W-1:0] sample_slope;
    } t_in;

    typedef struct packed {
        logic [OTIME_W-1:0]       bin_time;
        logic                     bin_valid;
        logic signed [DATA_W-1:0] mean_value;
        logic signed [DATA_W-1:0] mean_rms;
        logic signed [DATA_W-1:0] mean_slope;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

[sv/time_bin_sample_averager.sv]
`timescale 1ns / 1ps
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------
// in        | input     | i_in_valid / o_in_ready    | i_in  (t_in)
// out       | output    | o_out_valid / i_out_ready  | o_out (t_out)
// apb       | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// each transaction runs through accept, load, 44 steps of the bit-serial
// restoring dividers (three mean lanes share one step counter, the sample time
// modulo bin length runs in the first 32 of those steps), then the close step.
// i_rst_n is synchronous, active low; it opens no bin and restores the registers.
// a held result does not stop the next transaction; only a second closing bin waits
// in the close step until the output register is free.

module time_bin_sample_averager
    import tbsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state r_state, n_state;

    logic [BIN_W-1:0]  r_bin_sec;
    logic [TIME_W-1:0] r_period;

    logic                    r_open;
    logic [TIME_W-1:0]       r_first;
    logic signed [SUM_W-1:0] r_sum [LANES];
    logic [CNT_W-1:0]        r_count;

    logic [TIME_W-1:0] r_t;
    logic              r_t_nz;
    logic [BIN_W-1:0]  r_mod_rem;
    logic [TIME_W-1:0] r_mid;
    logic [STEP_W-1:0] r_step;

    logic [DIV_W-1:0]  r_q   [LANES];
    logic [CNT_W-1:0]  r_rem [LANES];
    logic              r_neg [LANES];

    t_out r_out;
    logic r_out_vld;

    logic s_accept, s_load, s_run, s_close, s_emit, s_last;
    logic [DATA_W-1:0] w_in_data [LANES];
    logic [BIN_W:0]    w_mod_tmp;
    logic [BIN_W-1:0]  w_mod_next;
    logic [CNT_W:0]    w_div_tmp [LANES];
    logic [CNT_W-1:0]  w_rem_next [LANES];
    logic              w_qbit [LANES];
    logic [TIME_W-1:0] w_first;
    logic              w_count_en;
    logic              w_cfg_wr;

    assign w_in_data[0] = i_in.sample_value;
    assign w_in_data[1] = i_in.sample_rms;
    assign w_in_data[2] = i_in.sample_slope;

    assign s_last  = (r_step == STEP_W'(DIV_W - 1));
    assign s_close = (r_bin_sec != '0) && r_t_nz && (r_mod_rem == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_RUN;
            ST_RUN: begin
                if (s_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!s_close || !r_out_vld || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        s_load     = 1'b0;
        s_run      = 1'b0;
        s_emit     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_LOAD: s_load     = 1'b1;
            ST_RUN:  s_run      = 1'b1;
            ST_DONE: s_emit     = s_close && (!r_out_vld || i_out_ready);
            default: o_in_ready = 1'b0;
        endcase
    end

    assign s_accept   = o_in_ready && i_in_valid;
    assign w_first    = r_open ? r_first : i_in.sample_time;
    assign w_count_en = i_in.sample_valid && (r_count < CNT_W'(MAX_SAMPLES_PER_BIN));

    // modulo step
    always_comb begin
        w_mod_tmp = {r_mod_rem, r_t[TIME_W-1]};
        if (w_mod_tmp >= {1'b0, r_bin_sec}) begin
            w_mod_next = BIN_W'(w_mod_tmp - {1'b0, r_bin_sec});
        end else begin
            w_mod_next = BIN_W'(w_mod_tmp);
        end
    end

    // divider lane steps
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_div_tmp[i] = {r_rem[i], r_q[i][DIV_W-1]};
            w_qbit[i]    = (w_div_tmp[i] >= {1'b0, r_count});
            if (w_qbit[i]) begin
                w_rem_next[i] = CNT_W'(w_div_tmp[i] - {1'b0, r_count});
            end else begin
                w_rem_next[i] = CNT_W'(w_div_tmp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // bin accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_first <= '0;
            r_count <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_sum[i] <= '0;
            end
        end else if (s_accept) begin
            r_open  <= 1'b1;
            r_first <= w_first;
            if (w_count_en) begin
                r_count <= r_count + CNT_W'(1);
                for (int i = 0; i < LANES; i++) begin
                    r_sum[i] <= r_sum[i] + SUM_W'(signed'(w_in_data[i]));
                end
            end
        end else if (s_emit) begin
            r_open  <= 1'b0;
            r_first <= '0;
            r_count <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_sum[i] <= '0;
            end
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_t       <= i_in.sample_time;
            r_t_nz    <= (i_in.sample_time != '0);
            r_mod_rem <= '0;
            r_mid     <= TIME_W'(({1'b0, w_first} + {1'b0, i_in.sample_time}) >> 1);
        end
        if (s_load) begin
            r_step <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_neg[i] <= r_sum[i][SUM_W-1];
                r_rem[i] <= '0;
                if (r_sum[i][SUM_W-1]) begin
                    r_q[i] <= DIV_W'(-r_sum[i]);
                end else begin
                    r_q[i] <= DIV_W'(r_sum[i]);
                end
            end
        end
        if (s_run) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step < STEP_W'(TIME_W)) begin
                r_mod_rem <= w_mod_next;
                r_t       <= {r_t[TIME_W-2:0], 1'b0};
            end
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= w_rem_next[i];
                r_q[i]   <= {r_q[i][DIV_W-2:0], w_qbit[i]};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out.bin_time  <= OTIME_W'(r_mid) + OTIME_W'(r_period);
            r_out.bin_valid <= (r_count != '0);
            if (r_count == '0) begin
                r_out.mean_value <= '0;
                r_out.mean_rms   <= '0;
                r_out.mean_slope <= '0;
            end else begin
                r_out.mean_value <= r_neg[0] ? -r_q[0][DATA_W-1:0] : r_q[0][DATA_W-1:0];
                r_out.mean_rms   <= r_neg[1] ? -r_q[1][DATA_W-1:0] : r_q[1][DATA_W-1:0];
                r_out.mean_slope <= r_neg[2] ? -r_q[2][DATA_W-1:0] : r_q[2][DATA_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_sec <= BIN_SECONDS_RST;
            r_period  <= PERIOD_START_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_BIN_SECONDS) begin
                r_bin_sec <= pwdata[BIN_W-1:0];
            end else begin
                r_period <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_PERIOD_START) ? r_period : 32'(r_bin_sec);
    assign pready = 1'b1;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import tbsa_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int SUBPHASES     = 6;
    localparam int MAX_REPORTS   = 10;
    localparam longint TIME_MAX  = 64'h0000_0000_FFFF_FFFF;

    localparam logic [APB_AW-1:0] ADDR_BIN_SECONDS  = {REG_BIN_SECONDS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_PERIOD_START = {REG_PERIOD_START, 2'b00};

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_TYPED,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_in               sample;
        logic              has_bin;
        t_out              bin;
        logic [APB_AW-1:0] addr;
        logic [31:0]       data;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              in_valid;
    logic              o_in_ready;
    t_in               in_data;
    logic              o_out_valid;
    logic              out_ready;
    t_out              o_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [BIN_W-1:0]  cfg_bin_len;
    logic [TIME_W-1:0] cfg_offset;
    longint            acc_value;
    longint            acc_rms;
    longint            acc_slope;
    int                acc_count;
    logic [TIME_W-1:0] first_time;
    bit                bin_is_open;

    t_out              pending_bins[$];
    t_stim_row         dir_rows[$];
    int                errors = 0;
    int                snd_idle = 32;
    int                rcv_idle = 52;
    int                hold_cnt = 0;

    time_bin_sample_averager i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void add_row(input t_stim_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void expect_bin(input t_out bin);
        pending_bins.insert(pending_bins.size(), bin);
    endfunction

    function automatic void clear_bin();
        acc_value   = 0;
        acc_rms     = 0;
        acc_slope   = 0;
        acc_count   = 0;
        first_time  = '0;
        bin_is_open = 1'b0;
    endfunction

    function automatic bit average_bin(input t_in s, output t_out r);
        logic [OTIME_W-1:0] mid;
        r = '0;
        if (!bin_is_open) begin
            first_time  = s.sample_time;
            bin_is_open = 1'b1;
        end
        if (s.sample_valid && acc_count < MAX_SAMPLES_PER_BIN) begin
            acc_value += longint'($signed(s.sample_value));
            acc_rms   += longint'($signed(s.sample_rms));
            acc_slope += longint'($signed(s.sample_slope));
            acc_count++;
        end
        if (cfg_bin_len != '0 && s.sample_time != '0 &&
            s.sample_time % TIME_W'(cfg_bin_len) == '0) begin
            mid = ({1'b0, first_time} + {1'b0, s.sample_time}) >> 1;
            r.bin_time = mid + {1'b0, cfg_offset};
            if (acc_count != 0) begin
                r.bin_valid  = 1'b1;
                r.mean_value = DATA_W'(acc_value / longint'(acc_count));
                r.mean_rms   = DATA_W'(acc_rms / longint'(acc_count));
                r.mean_slope = DATA_W'(acc_slope / longint'(acc_count));
            end
            clear_bin();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_in mk_sample(input logic [TIME_W-1:0] t, input logic v,
                                      input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                      input logic [DATA_W-1:0] c);
        t_in s;
        s.sample_time  = t;
        s.sample_valid = v;
        s.sample_value = a;
        s.sample_rms   = b;
        s.sample_slope = c;
        return s;
    endfunction

    function automatic t_out mk_bin(input logic [OTIME_W-1:0] t, input logic v,
                                    input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                    input logic [DATA_W-1:0] c);
        t_out r;
        r.bin_time   = t;
        r.bin_valid  = v;
        r.mean_value = a;
        r.mean_rms   = b;
        r.mean_slope = c;
        return r;
    endfunction

    function automatic t_stim_row row_sample(input t_row_kind kind, input t_in s,
                                             input logic has_bin, input t_out bin);
        t_stim_row row;
        row = '0;
        row.kind    = kind;
        row.sample  = s;
        row.has_bin = has_bin;
        row.bin     = bin;
        return row;
    endfunction

    function automatic t_stim_row row_cfg(input logic [APB_AW-1:0] addr,
                                          input logic [31:0] data);
        t_stim_row row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.addr = addr;
        row.data = data;
        return row;
    endfunction

    function automatic logic [DATA_W-1:0] rand_q();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // starts and ends at a falling edge, valid is left high
    task automatic send_sample(input t_in s, input bit typed, input bit has_bin,
                               input t_out bin);
        t_out r;
        bit closed;
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        closed = average_bin(s, r);
        if (typed) begin
            if (has_bin)
                expect_bin(bin);
        end else if (closed) begin
            expect_bin(r);
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bins.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_BIN_SECONDS) begin
            cfg_bin_len = data[BIN_W-1:0];
            readback    = 32'(data[BIN_W-1:0]);
        end else begin
            cfg_offset = data;
            readback   = data;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("register read at %h: expected %h, got %h", addr, readback, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly well-formed bins: a few samples inside one bin period, then the closing time
    task automatic send_random_bins(input int n_items);
        int                sent;
        int                n_open;
        bit                dead;
        longint            span;
        longint            base;
        logic [TIME_W-1:0] t;
        sent = 0;
        span = longint'(cfg_bin_len);
        while (sent < n_items) begin
            if ($urandom_range(9) == 0 || span == 0) begin
                t = ($urandom_range(3) == 0) ? '0 : $urandom;
                send_sample(mk_sample(t, 1'($urandom_range(1)), rand_q(), rand_q(), rand_q()),
                            1'b0, 1'b0, '0);
                sent++;
            end else begin
                n_open = (span > 1) ? $urandom_range(5) : 0;
                dead   = ($urandom_range(7) == 0);
                base   = longint'($urandom_range(32'(TIME_MAX / span - 1))) * span;
                for (int j = 0; j < n_open; j++) begin
                    t = TIME_W'(base + longint'($urandom_range(32'(span - 1), 1)));
                    send_sample(mk_sample(t, !dead && $urandom_range(9) != 0,
                                          rand_q(), rand_q(), rand_q()), 1'b0, 1'b0, '0);
                    sent++;
                end
                t = TIME_W'(base + span);
                send_sample(mk_sample(t, !dead && $urandom_range(9) != 0,
                                      rand_q(), rand_q(), rand_q()), 1'b0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver side
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                out_ready <= 1'b0;
                hold_cnt--;
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // result checker
    initial begin
        t_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && out_ready === 1'b1) begin
                if (pending_bins.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("bin result with none expected: %h", o_out);
                end else begin
                    want = pending_bins[0];
                    pending_bins.delete(0);
                    if (o_out.bin_time !== want.bin_time ||
                        o_out.bin_valid !== want.bin_valid ||
                        o_out.mean_value !== want.mean_value ||
                        o_out.mean_rms !== want.mean_rms ||
                        o_out.mean_slope !== want.mean_slope) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("bin mismatch: expected %h %b %h %h %h, got %h %b %h %h %h",
                                     want.bin_time, want.bin_valid, want.mean_value,
                                     want.mean_rms, want.mean_slope,
                                     o_out.bin_time, o_out.bin_valid, o_out.mean_value,
                                     o_out.mean_rms, o_out.mean_slope);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_stim_row         row;
        logic [BIN_W-1:0]  len;
        logic [TIME_W-1:0] offset;

        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // time zero opens, mid time, extremes, empty bin
        add_row(row_sample(ROW_TYPED,
            mk_sample(32'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001), 1'b0, '0));
        add_row(row_sample(ROW_TYPED,
            mk_sample(32'd3600, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
            mk_bin(33'd1800, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000)));
        add_row(row_sample(ROW_TYPED,
            mk_sample(32'd7200, 1'b0, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F), 1'b1,
            mk_bin(33'd7200, 1'b0, 32'h0, 32'h0, 32'h0)));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd7201, 1'b1, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd7300, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd7500, 1'b1, 32'h0003_0001, 32'h0000_0000, 32'h8000_0000), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd10800, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0003), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF),
            1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd4294965600, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0),
            1'b0, '0));
        add_row(row_cfg(ADDR_PERIOD_START, 32'hFFFF_FFFF));
        add_row(row_cfg(ADDR_BIN_SECONDS, 32'd1));
        add_row(row_sample(ROW_TYPED,
            mk_sample(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
            mk_bin(33'h1_FFFF_FFFE, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF)));
        add_row(row_sample(ROW_TYPED,
            mk_sample(32'd0, 1'b1, 32'h0000_0040, 32'h0, 32'h0), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd5, 1'b1, 32'hFFFF_FFC0, 32'h0000_0001, 32'h0000_0002), 1'b0, '0));
        // zero bin length, then a bin left open across a write
        add_row(row_cfg(ADDR_BIN_SECONDS, 32'd0));
        add_row(row_cfg(ADDR_PERIOD_START, 32'd0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd10, 1'b1, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_0007), 1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
            1'b0, '0));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd3600, 1'b1, 32'h8000_0001, 32'h0000_0003, 32'hFFFF_FFF9), 1'b0, '0));
        add_row(row_cfg(ADDR_BIN_SECONDS, 32'h00FF_FFFF));
        add_row(row_sample(ROW_MODEL,
            mk_sample(32'd33554430, 1'b1, 32'h0000_0005, 32'h8000_0000, 32'h7FFF_FFFF),
            1'b0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_bin_len = BIN_SECONDS_RST;
        cfg_offset  = PERIOD_START_RST;
        clear_bin();
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CONFIG) begin
                settle();
                write_reg(row.addr, row.data);
            end else begin
                send_sample(row.sample, row.kind == ROW_TYPED, row.has_bin, row.bin);
            end
        end

        for (int p = 0; p < 3; p++) begin
            snd_idle = (p == 0) ? 32 : (p == 1) ? 52 : 0;
            rcv_idle = (p == 0) ? 52 : (p == 1) ? 32 : 0;
            for (int sp = 0; sp < SUBPHASES; sp++) begin
                settle();
                case (sp)
                    0: len = BIN_W'(1);
                    1: len = BIN_W'($urandom_range(12, 2));
                    2: len = BIN_SECONDS_RST;
                    3: len = '1;
                    4: len = BIN_W'($urandom_range(32'h00FF_FFFF, 1));
                    default: len = BIN_W'($urandom_range(200, 13));
                endcase
                case (sp % 3)
                    0: offset = '0;
                    1: offset = '1;
                    default: offset = $urandom;
                endcase
                write_reg(ADDR_BIN_SECONDS, 32'(len));
                write_reg(ADDR_PERIOD_START, offset);
                // every sample with a nonzero time closes a bin here, so a long receiver stall fills the block
                if (p == 0 && sp == 0)
                    hold_cnt = HOLD_CYCLES;
                send_random_bins(RANDOM_ITEMS / (3 * SUBPHASES));
            end
        end

        settle();

        errors += pending_bins.size();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
